FILE: rtl/core/pts_pkg.sv
// Shared types and constants for the periodic task release scheduler.
package pts_pkg;

    localparam int NUM_SLOTS_DEF = 8;

    localparam int HANDLE_W = 8;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = 3;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_CREATE = 1'b1;

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef struct packed {
        logic                op;
        logic [HANDLE_W-1:0] task_handle;
        logic [TIME_W-1:0]   period;
        logic [TIME_W-1:0]   first_delay;
    } t_in_beat;

    typedef struct packed {
        logic                kind;
        logic [HANDLE_W-1:0] released_handle;
        logic [SLOT_W-1:0]   slot;
        logic                accepted;
        logic                last;
    } t_out_beat;

    // One entry of the slot table memory.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   period;
        logic [TIME_W-1:0]   countdown;
    } t_slot_entry;

    // Requests from the sequencer to the output stage.
    typedef struct packed {
        logic push_rel;
        logic push_ack;
        logic flush;
    } t_ostg_ctl;

    // Status from the output stage back to the sequencer.
    typedef struct packed {
        logic out_free;
        logic pend_v;
    } t_ostg_sts;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_FLUSH,
        ST_CREATE
    } t_state;

endpackage

FILE: rtl/core/periodic_task_release_scheduler.sv
// Top level of the periodic task release scheduler: slot table memory and sequencer.
//
// Input beats carry an op: a tick walks the task table, a create registers a task.
// Both channels use valid/stall; a beat moves when valid is high and stall is low.
// The block takes one input beat at a time: o_in_stall is high from the accepted
// beat until every result it causes has been handed to the output stage.
// A tick walks all NUM_SLOTS slots, one slot per cycle while the output is not
// stalled, through a single-port read and a write-back of the slot memory, and
// holds o_in_stall high until the walk is over and any held release has been
// passed to the output register. Each release found by the walk
// produces one output beat; a tick with no due task produces none. The newest
// release is held back one step so its last flag can be set once the walk is over.
// A create searches the occupancy bits one slot per cycle for the lowest free slot
// and answers with one acknowledgement beat.
// Reset (synchronous, active low) clears the occupancy bits, which is all the
// table needs: the memory itself is never read for a slot that was not written.
// No clearing pass runs, so the block takes input as soon as reset is released.
// When the receiver stalls, the output register holds its beat; once the holding
// stage is also full the tick walk pauses in place and resumes when space frees.
module periodic_task_release_scheduler
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_beat,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_beat,
    input  logic      i_out_stall
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    // Sequencer state.
    t_state         r_state;
    t_state         n_state;
    logic [IW-1:0]  r_idx;
    logic           r_iss_done;
    logic           r_s2_v;
    logic [IW-1:0]  r_s2_idx;
    t_in_beat       r_cr;

    // Slot table: occupancy in flops, everything else in the memory.
    logic [NUM_SLOTS-1:0] r_occ;
    t_slot_entry          r_mem [NUM_SLOTS];
    t_slot_entry          r_rd_data;

    // Control produced by the output decode.
    logic          in_accept;
    logic          mem_re;
    logic          mem_we;
    logic [IW-1:0] we_addr;
    t_slot_entry   we_data;
    logic          occ_we;
    logic          advance;
    logic          issue;
    logic          s2_emit;
    logic          s2_go;
    logic          cur_free;
    logic          at_end;

    t_ostg_ctl ostg_ctl;
    t_ostg_sts ostg_sts;
    t_out_beat ostg_beat;

    assign in_accept  = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    // A release waits in the holding stage, so it can enter whenever that stage
    // is empty or the output register can take the older one.
    assign s2_emit  = (r_rd_data.countdown == '0);
    assign s2_go    = r_s2_v && (!s2_emit || !ostg_sts.pend_v || ostg_sts.out_free);
    assign advance  = !r_s2_v || s2_go;
    assign cur_free = !r_occ[r_idx];
    assign at_end   = (r_idx == LAST_IDX);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in_beat.op == OP_CREATE) ? ST_CREATE : ST_TICK;
                end
            end
            ST_TICK: begin
                if (r_iss_done && !r_s2_v) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!ostg_sts.pend_v || ostg_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CREATE: begin
                if (ostg_sts.out_free && (cur_free || at_end)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory port control and output stage requests.
    always_comb begin
        issue     = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        we_addr   = r_s2_idx;
        we_data   = r_rd_data;
        occ_we    = 1'b0;
        ostg_ctl  = '0;
        ostg_beat = '0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_TICK: begin
                // Read the slot at r_idx while the previous slot is written back.
                issue  = advance && !r_iss_done;
                mem_re = issue && r_occ[r_idx];
                mem_we = s2_go;
                we_data.countdown = s2_emit ? (r_rd_data.period - 32'd1)
                                            : (r_rd_data.countdown - 32'd1);
                ostg_ctl.push_rel         = s2_go && s2_emit;
                ostg_beat.kind            = KIND_RELEASE;
                ostg_beat.released_handle = r_rd_data.handle;
                ostg_beat.slot            = SLOT_W'(r_s2_idx);
            end
            ST_FLUSH: begin
                ostg_ctl.flush = 1'b1;
            end
            ST_CREATE: begin
                ostg_beat.kind = KIND_ACK;
                if (ostg_sts.out_free && cur_free) begin
                    mem_we            = 1'b1;
                    we_addr           = r_idx;
                    we_data.handle    = r_cr.task_handle;
                    we_data.period    = r_cr.period;
                    we_data.countdown = r_cr.first_delay;
                    occ_we            = 1'b1;
                    ostg_ctl.push_ack  = 1'b1;
                    ostg_beat.slot     = SLOT_W'(r_idx);
                    ostg_beat.accepted = 1'b1;
                end else if (ostg_sts.out_free && at_end) begin
                    // Table full: refuse, reported against slot zero.
                    ostg_ctl.push_ack = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_iss_done <= 1'b0;
            r_s2_v     <= 1'b0;
            r_occ      <= '0;
        end else begin
            r_state <= n_state;
            if (occ_we) begin
                r_occ[r_idx] <= (r_cr.task_handle != '0);
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_idx      <= '0;
                    r_iss_done <= 1'b0;
                    r_s2_v     <= 1'b0;
                end
                ST_TICK: begin
                    if (issue) begin
                        if (at_end) begin
                            r_iss_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (advance) begin
                        r_s2_v <= mem_re;
                    end
                end
                ST_FLUSH: begin
                    r_s2_v <= 1'b0;
                end
                ST_CREATE: begin
                    if (!cur_free && !at_end) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cr <= i_in_beat;
        end
        if (advance) begin
            r_s2_idx <= r_idx;
        end
    end

    // Slot memory: one write port, one registered read port. Reads only happen
    // on advance, so a paused walk keeps its read data in place.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[we_addr] <= we_data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    pts_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ostg_ctl),
        .i_beat      (ostg_beat),
        .o_sts       (ostg_sts),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: rtl/core/pts_out_stage.sv
// Output stage: holds the newest release until the last flag is known, then the output register.
module pts_out_stage
    import pts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ostg_ctl i_ctl,
    input  t_out_beat i_beat,
    output t_ostg_sts o_sts,
    output logic      o_out_valid,
    output t_out_beat o_out_beat,
    input  logic      i_out_stall
);

    logic      r_out_v;
    t_out_beat r_out;
    logic      r_pend_v;
    t_out_beat r_pend;
    logic      out_free;
    logic      flush_go;
    t_out_beat pend_mid;
    t_out_beat pend_end;
    t_out_beat ack_beat;

    assign out_free = !r_out_v || !i_out_stall;
    assign flush_go = i_ctl.flush && r_pend_v && out_free;

    assign o_sts.out_free = out_free;
    assign o_sts.pend_v   = r_pend_v;
    assign o_out_valid    = r_out_v;
    assign o_out_beat     = r_out;

    // A held release that is pushed out by a newer one is not the last of its tick;
    // the one that leaves on the flush is.
    always_comb begin
        pend_mid      = r_pend;
        pend_mid.last = 1'b0;
        pend_end      = r_pend;
        pend_end.last = 1'b1;
        ack_beat      = i_beat;
        ack_beat.last = 1'b1;
    end

    // The sequencer only pushes when the status allows it, so a load of the
    // output register always finds it free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_ctl.push_rel && r_pend_v) begin
                r_out_v <= 1'b1;
                r_out   <= pend_mid;
            end else if (i_ctl.push_ack) begin
                r_out_v <= 1'b1;
                r_out   <= ack_beat;
            end else if (flush_go) begin
                r_out_v <= 1'b1;
                r_out   <= pend_end;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end

            if (i_ctl.push_rel) begin
                r_pend_v <= 1'b1;
                r_pend   <= i_beat;
            end else if (flush_go) begin
                r_pend_v <= 1'b0;
            end
        end
    end

endmodule

FILE: dv/pts_release_checker.sv
// Checker for the periodic task release scheduler: slot table predictor and beat comparison.
module pts_release_checker
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_beat,
    input  logic      i_in_stall,
    input  logic      i_out_valid,
    input  t_out_beat i_out_beat,
    input  logic      i_out_stall,
    output int        o_mismatches,
    output int        o_owed
);

    logic [HANDLE_W-1:0] task_of      [NUM_SLOTS];
    logic [TIME_W-1:0]   period_of    [NUM_SLOTS];
    logic [TIME_W-1:0]   countdown_of [NUM_SLOTS];

    t_out_beat owed_beats[$];
    int        mismatch_count = 0;
    int        owed_count     = 0;

    assign o_mismatches = mismatch_count;
    assign o_owed       = owed_count;

    // A create takes the lowest slot whose handle is zero; a zero handle leaves it free.
    task automatic register_task(input t_in_beat b);
        t_out_beat ack;
        int        free_slot;
        free_slot = -1;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (task_of[k] == '0 && free_slot < 0) free_slot = k;
        end
        ack      = '0;
        ack.kind = KIND_ACK;
        ack.last = 1'b1;
        if (free_slot >= 0) begin
            task_of[free_slot]      = b.task_handle;
            period_of[free_slot]    = b.period;
            countdown_of[free_slot] = b.first_delay;
            ack.slot                = SLOT_W'(free_slot);
            ack.accepted            = 1'b1;
        end
        owed_beats.push_back(ack);
    endtask

    // A tick releases every occupied slot that has counted down to zero.
    task automatic release_due_tasks();
        t_out_beat rel;
        int        found;
        found = 0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (task_of[k] != '0) begin
                if (countdown_of[k] == '0) begin
                    rel                 = '0;
                    rel.kind            = KIND_RELEASE;
                    rel.released_handle = task_of[k];
                    rel.slot            = SLOT_W'(k);
                    owed_beats.push_back(rel);
                    found++;
                    countdown_of[k] = period_of[k] - 1'b1;
                end else begin
                    countdown_of[k] = countdown_of[k] - 1'b1;
                end
            end
        end
        if (found > 0) begin
            rel      = owed_beats[owed_beats.size() - 1];
            rel.last = 1'b1;
            owed_beats[owed_beats.size() - 1] = rel;
        end
    endtask

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        int        bad;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                task_of[k]      = '0;
                period_of[k]    = '0;
                countdown_of[k] = '0;
            end
            owed_beats.delete();
        end else begin
            // Results are checked before the input of the same edge is predicted.
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (owed_beats.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, got %p",
                             $time, i_out_beat);
                    mismatch_count++;
                end else begin
                    want = owed_beats.pop_front();
                    bad  = field_differs("kind", 32'(want.kind), 32'(i_out_beat.kind))
                         + field_differs("released_handle", 32'(want.released_handle),
                                         32'(i_out_beat.released_handle))
                         + field_differs("slot", 32'(want.slot), 32'(i_out_beat.slot))
                         + field_differs("accepted", 32'(want.accepted),
                                         32'(i_out_beat.accepted))
                         + field_differs("last", 32'(want.last), 32'(i_out_beat.last));
                    if (bad != 0) mismatch_count++;
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                if (i_in_beat.op == OP_CREATE) register_task(i_in_beat);
                else release_due_tasks();
            end
        end
        owed_count = owed_beats.size();
    end

endmodule

FILE: dv/tb_periodic_task_release_scheduler.sv
// Testbench top for the periodic task release scheduler: stimulus, handshakes and verdict.
module tb_periodic_task_release_scheduler;
    import pts_pkg::*;

    localparam int RANDOM_BEATS = 320;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    t_in_beat  in_beat;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;
    logic      out_stall;

    int mismatches;
    int owed;
    int cycles = 0;
    bit tx_calm;
    int rx_calm_left;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    periodic_task_release_scheduler DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_beat   (in_beat),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_beat  (out_beat),
        .i_out_stall (out_stall)
    );

    pts_release_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_beat    (in_beat),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_beat   (out_beat),
        .i_out_stall  (out_stall),
        .o_mismatches (mismatches),
        .o_owed       (owed)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_periodic_task_release_scheduler: done, errors");
            $finish;
        end
    end

    function automatic t_in_beat create_beat(input logic [HANDLE_W-1:0] handle,
                                             input logic [TIME_W-1:0] period,
                                             input logic [TIME_W-1:0] delay);
        t_in_beat b;
        b.op          = OP_CREATE;
        b.task_handle = handle;
        b.period      = period;
        b.first_delay = delay;
        return b;
    endfunction

    // Ticks carry random content in the fields that only a create uses.
    function automatic t_in_beat tick_beat();
        t_in_beat b;
        b.op          = OP_TICK;
        b.task_handle = HANDLE_W'($urandom_range(255, 0));
        b.period      = $urandom();
        b.first_delay = $urandom();
        return b;
    endfunction

    // Idle for a random gap, then present the beat and hold it until it is taken.
    task automatic send_beat(input t_in_beat b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(19, 0);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_beat(tick_beat());
    endtask

    // Result side: a random stall before each beat, with calm stretches of no stall.
    task automatic take_results();
        int hold;
        forever begin
            @(negedge clk);
            if (rx_calm_left > 0) begin
                hold = 0;
                rx_calm_left--;
            end else begin
                hold = $urandom_range(19, 0);
                if ($urandom_range(7, 0) == 0) rx_calm_left = $urandom_range(40, 10);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    endtask

    initial begin
        t_in_beat b;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_beat      = '0;
        out_stall    = 1'b0;
        tx_calm      = 1'b0;
        rx_calm_left = 0;
        fork
            take_results();
        join_none
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. A tick on the empty table gives no result, and a create with
        // a zero handle is acknowledged but leaves its slot free for the next create.
        send_ticks(1);
        send_beat(create_beat(8'h00, 32'd3, 32'd5));
        send_ticks(1);
        // Fill the table, every task due on the first tick so that one tick releases all
        // eight. A zero period wraps its reload to all ones; the largest period reloads to all ones less one.
        send_beat(create_beat(8'hFF, 32'd1, 32'd0));
        send_beat(create_beat(8'h01, 32'd0, 32'd0));
        send_beat(create_beat(8'h80, 32'hFFFF_FFFF, 32'd0));
        send_beat(create_beat(8'h7F, 32'd2, 32'd0));
        send_beat(create_beat(8'h55, 32'd3, 32'd0));
        send_beat(create_beat(8'hAA, 32'd1, 32'd0));
        send_beat(create_beat(8'h33, 32'd5, 32'd0));
        send_beat(create_beat(8'hCC, 32'd4, 32'd0));
        // The table is full now, so this create is refused.
        send_beat(create_beat(8'h11, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_ticks(10);

        // Random part: mostly ticks against the full table, with refused creates that
        // carry random fields. The sender now and then runs a calm stretch without gaps.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 40 == 0) tx_calm = ($urandom_range(3, 0) == 0);
            if ($urandom_range(4, 0) == 0) begin
                b = create_beat(HANDLE_W'($urandom_range(255, 1)), $urandom(), $urandom());
            end else begin
                b = tick_beat();
            end
            send_beat(b);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (owed != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && owed == 0) begin
            $display("tb_periodic_task_release_scheduler: done, clean");
        end else begin
            $display("tb_periodic_task_release_scheduler: done, errors");
        end
        $finish;
    end

endmodule
